// File: hw/rtl/sbo_pkg.sv
// Shared types and codes for the segment/box overlap classifier.
package sbo_pkg;

    localparam int LEVEL_BITS   = 6;
    localparam int CLASS_BITS   = 2;
    localparam int REG_IDX_BITS = 2;

    localparam logic [CLASS_BITS-1:0] CLS_NONE = 2'd0;
    localparam logic [CLASS_BITS-1:0] CLS_PART = 2'd1;
    localparam logic [CLASS_BITS-1:0] CLS_FULL = 2'd2;

    localparam logic [REG_IDX_BITS-1:0] REG_SEG_START_X = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_SEG_START_Y = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_SEG_END_X   = 2'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_SEG_END_Y   = 2'd3;

    typedef struct packed {
        logic                  start_in;
        logic                  end_in;
        logic [LEVEL_BITS-1:0] level;
    } sbo_tag_t;

    localparam int TAG_BITS = $bits(sbo_tag_t);

endpackage

// File: hw/rtl/segment_box_overlap_classifier_top.sv
// Top level: segment registers, front part, queue and back part.
// Path: a box accepted by the front register passes through the queue, the
// product stage, the difference stage and the result register.
// Throughput: one box per cycle while out_ready is held high; the ten cross-product
// multipliers of the back part are fully pipelined, and the two-entry queue absorbs front/back skew.
// Reset: asynchronous, active low; clears the segment registers to zero and
// empties the front register, queue and back pipeline.
module segment_box_overlap_classifier_top #(
    parameter int COORD_BITS  = 32,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wen,
    input  logic [sbo_pkg::REG_IDX_BITS-1:0]    cfg_addr,
    input  logic [COORD_BITS-1:0]               cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [COORD_BITS-1:0]        box_min_x,
    input  logic signed [COORD_BITS-1:0]        box_max_x,
    input  logic signed [COORD_BITS-1:0]        box_min_y,
    input  logic signed [COORD_BITS-1:0]        box_max_y,
    input  logic [sbo_pkg::LEVEL_BITS-1:0]      tree_level,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sbo_pkg::CLASS_BITS-1:0]      within_class,
    output logic [sbo_pkg::LEVEL_BITS-1:0]      score
);
    import sbo_pkg::*;

    localparam int D       = COORD_BITS + 1;
    localparam int ENTRY_W = TAG_BITS + 6 * D;

    logic signed [COORD_BITS-1:0] seg_start_x_reg, seg_start_x_next;
    logic signed [COORD_BITS-1:0] seg_start_y_reg, seg_start_y_next;
    logic signed [COORD_BITS-1:0] seg_end_x_reg, seg_end_x_next;
    logic signed [COORD_BITS-1:0] seg_end_y_reg, seg_end_y_next;

    logic                push, push_ready, pop, q_valid;
    sbo_tag_t            f_tag, q_tag;
    logic signed [D-1:0] f_vx, f_vy1, f_vy2, f_wx, f_wy1, f_wy2;
    logic signed [D-1:0] q_vx, q_vy1, q_vy2, q_wx, q_wy1, q_wy2;
    logic [ENTRY_W-1:0]  push_data, pop_data;

    always_comb
    begin
        seg_start_x_next = seg_start_x_reg;
        seg_start_y_next = seg_start_y_reg;
        seg_end_x_next   = seg_end_x_reg;
        seg_end_y_next   = seg_end_y_reg;
        if (cfg_wen)
        begin
            unique case (cfg_addr)
                REG_SEG_START_X: seg_start_x_next = $signed(cfg_wdata);
                REG_SEG_START_Y: seg_start_y_next = $signed(cfg_wdata);
                REG_SEG_END_X:   seg_end_x_next   = $signed(cfg_wdata);
                REG_SEG_END_Y:   seg_end_y_next   = $signed(cfg_wdata);
                default:         seg_start_x_next = seg_start_x_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_start_x_reg <= '0;
            seg_start_y_reg <= '0;
            seg_end_x_reg   <= '0;
            seg_end_y_reg   <= '0;
        end
        else
        begin
            seg_start_x_reg <= seg_start_x_next;
            seg_start_y_reg <= seg_start_y_next;
            seg_end_x_reg   <= seg_end_x_next;
            seg_end_y_reg   <= seg_end_y_next;
        end
    end

    sbo_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .box_min_x   (box_min_x),
        .box_max_x   (box_max_x),
        .box_min_y   (box_min_y),
        .box_max_y   (box_max_y),
        .tree_level  (tree_level),
        .seg_start_x (seg_start_x_reg),
        .seg_start_y (seg_start_y_reg),
        .seg_end_x   (seg_end_x_reg),
        .seg_end_y   (seg_end_y_reg),
        .push        (push),
        .push_ready  (push_ready),
        .tag         (f_tag),
        .vx          (f_vx),
        .vy1         (f_vy1),
        .vy2         (f_vy2),
        .wx          (f_wx),
        .wy1         (f_wy1),
        .wy2         (f_wy2)
    );

    assign push_data = {f_tag, f_vx, f_vy1, f_vy2, f_wx, f_wy1, f_wy2};

    sbo_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .not_full  (push_ready),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (q_valid)
    );

    assign q_tag = sbo_tag_t'(pop_data[ENTRY_W-1 -: TAG_BITS]);
    assign q_vx  = $signed(pop_data[6*D-1 -: D]);
    assign q_vy1 = $signed(pop_data[5*D-1 -: D]);
    assign q_vy2 = $signed(pop_data[4*D-1 -: D]);
    assign q_wx  = $signed(pop_data[3*D-1 -: D]);
    assign q_wy1 = $signed(pop_data[2*D-1 -: D]);
    assign q_wy2 = $signed(pop_data[D-1 -: D]);

    sbo_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .pop          (pop),
        .tag          (q_tag),
        .vx           (q_vx),
        .vy1          (q_vy1),
        .vy2          (q_vy2),
        .wx           (q_wx),
        .wy1          (q_wy1),
        .wy2          (q_wy2),
        .seg_start_x  (seg_start_x_reg),
        .seg_start_y  (seg_start_y_reg),
        .seg_end_x    (seg_end_x_reg),
        .seg_end_y    (seg_end_y_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .within_class (within_class),
        .score        (score)
    );

endmodule

// File: hw/rtl/sbo_queue.sv
// Short register queue that decouples the front and back parts.
module sbo_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             not_full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign not_full  = (count_reg != CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + CW'(1))
        else $error("queue count did not grow on push");

endmodule

// File: hw/rtl/sbo_front.sv
// Front part: takes box requests, tests the endpoints and forms the differences.
module sbo_front #(
    parameter int COORD_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [COORD_BITS-1:0]       box_min_x,
    input  logic signed [COORD_BITS-1:0]       box_max_x,
    input  logic signed [COORD_BITS-1:0]       box_min_y,
    input  logic signed [COORD_BITS-1:0]       box_max_y,
    input  logic [sbo_pkg::LEVEL_BITS-1:0]     tree_level,
    input  logic signed [COORD_BITS-1:0]       seg_start_x,
    input  logic signed [COORD_BITS-1:0]       seg_start_y,
    input  logic signed [COORD_BITS-1:0]       seg_end_x,
    input  logic signed [COORD_BITS-1:0]       seg_end_y,
    output logic                               push,
    input  logic                               push_ready,
    output sbo_pkg::sbo_tag_t                  tag,
    output logic signed [COORD_BITS:0]         vx,
    output logic signed [COORD_BITS:0]         vy1,
    output logic signed [COORD_BITS:0]         vy2,
    output logic signed [COORD_BITS:0]         wx,
    output logic signed [COORD_BITS:0]         wy1,
    output logic signed [COORD_BITS:0]         wy2
);
    import sbo_pkg::*;

    localparam int D = COORD_BITS + 1;

    logic signed [D-1:0] x0, x1, y0, y1, sx, sy;
    logic                accept;
    logic                start_in, end_in;
    logic                valid_reg, valid_next;
    sbo_tag_t            tag_reg;
    logic signed [D-1:0] vx_reg, vy1_reg, vy2_reg, wx_reg, wy1_reg, wy2_reg;

    assign x0 = $signed({box_min_x[COORD_BITS-1], box_min_x});
    assign x1 = $signed({box_max_x[COORD_BITS-1], box_max_x});
    assign y0 = $signed({box_min_y[COORD_BITS-1], box_min_y});
    assign y1 = $signed({box_max_y[COORD_BITS-1], box_max_y});
    assign sx = $signed({seg_start_x[COORD_BITS-1], seg_start_x});
    assign sy = $signed({seg_start_y[COORD_BITS-1], seg_start_y});

    // inclusive on every box edge
    assign start_in = (box_min_x <= seg_start_x) && (seg_start_x <= box_max_x) &&
                      (box_min_y <= seg_start_y) && (seg_start_y <= box_max_y);
    assign end_in   = (box_min_x <= seg_end_x) && (seg_end_x <= box_max_x) &&
                      (box_min_y <= seg_end_y) && (seg_end_y <= box_max_y);

    assign push     = valid_reg && push_ready;
    assign in_ready = !valid_reg || push_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // diagonals: (x0,y0)-(x1,y1) and (x0,y1)-(x1,y0)
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tag_reg.start_in <= start_in;
            tag_reg.end_in   <= end_in;
            tag_reg.level    <= tree_level;
            vx_reg           <= x1 - x0;
            vy1_reg          <= y1 - y0;
            vy2_reg          <= y0 - y1;
            wx_reg           <= x0 - sx;
            wy1_reg          <= y0 - sy;
            wy2_reg          <= y1 - sy;
        end
    end

    assign tag = tag_reg;
    assign vx  = vx_reg;
    assign vy1 = vy1_reg;
    assign vy2 = vy2_reg;
    assign wx  = wx_reg;
    assign wy1 = wy1_reg;
    assign wy2 = wy2_reg;

endmodule

// File: hw/rtl/sbo_back.sv
// Back part: cross products, crossing tests and the result register.
module sbo_back #(
    parameter int COORD_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    output logic                               pop,
    input  sbo_pkg::sbo_tag_t                  tag,
    input  logic signed [COORD_BITS:0]         vx,
    input  logic signed [COORD_BITS:0]         vy1,
    input  logic signed [COORD_BITS:0]         vy2,
    input  logic signed [COORD_BITS:0]         wx,
    input  logic signed [COORD_BITS:0]         wy1,
    input  logic signed [COORD_BITS:0]         wy2,
    input  logic signed [COORD_BITS-1:0]       seg_start_x,
    input  logic signed [COORD_BITS-1:0]       seg_start_y,
    input  logic signed [COORD_BITS-1:0]       seg_end_x,
    input  logic signed [COORD_BITS-1:0]       seg_end_y,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [sbo_pkg::CLASS_BITS-1:0]     within_class,
    output logic [sbo_pkg::LEVEL_BITS-1:0]     score
);
    import sbo_pkg::*;

    localparam int D = COORD_BITS + 1;
    localparam int P = 2 * D;
    localparam int W = P + 1;
    localparam logic signed [W-1:0] ZERO = '0;

    // true when num/den lies in [0,1], den nonzero
    function automatic logic in_unit(input logic signed [W-1:0] num,
                                     input logic signed [W-1:0] den);
        return (den >= ZERO) ? ((num >= ZERO) && (num <= den))
                             : ((num >= den) && (num <= ZERO));
    endfunction

    logic                en;
    logic signed [D-1:0] ux, uy;

    logic                b1_valid_reg, b1_valid_next;
    sbo_tag_t            b1_tag_reg;
    logic signed [P-1:0] p_ux_vy1_reg, p_ux_vy2_reg, p_uy_vx_reg;
    logic signed [P-1:0] p_wx_vy1_reg, p_wx_vy2_reg, p_wy1_vx_reg, p_wy2_vx_reg;
    logic signed [P-1:0] p_wx_uy_reg, p_wy1_ux_reg, p_wy2_ux_reg;

    logic                b2_valid_reg, b2_valid_next;
    sbo_tag_t            b2_tag_reg;
    logic signed [W-1:0] den1_reg, tn1_reg, un1_reg;
    logic signed [W-1:0] den2_reg, tn2_reg, un2_reg;

    logic                   cross1, cross2;
    logic [CLASS_BITS-1:0]  cls;
    logic                   out_valid_reg, out_valid_next;
    logic [CLASS_BITS-1:0]  within_class_reg;
    logic [LEVEL_BITS-1:0]  score_reg;

    // the whole back pipeline holds while a result waits
    assign en  = !out_valid_reg || out_ready;
    assign pop = en && q_valid;

    assign ux = $signed({seg_end_x[COORD_BITS-1], seg_end_x}) -
                $signed({seg_start_x[COORD_BITS-1], seg_start_x});
    assign uy = $signed({seg_end_y[COORD_BITS-1], seg_end_y}) -
                $signed({seg_start_y[COORD_BITS-1], seg_start_y});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_tag_reg   <= tag;
            p_ux_vy1_reg <= P'(ux) * P'(vy1);
            p_ux_vy2_reg <= P'(ux) * P'(vy2);
            p_uy_vx_reg  <= P'(uy) * P'(vx);
            p_wx_vy1_reg <= P'(wx) * P'(vy1);
            p_wx_vy2_reg <= P'(wx) * P'(vy2);
            p_wy1_vx_reg <= P'(wy1) * P'(vx);
            p_wy2_vx_reg <= P'(wy2) * P'(vx);
            p_wx_uy_reg  <= P'(wx) * P'(uy);
            p_wy1_ux_reg <= P'(wy1) * P'(ux);
            p_wy2_ux_reg <= P'(wy2) * P'(ux);

            b2_tag_reg <= b1_tag_reg;
            den1_reg   <= W'(p_ux_vy1_reg) - W'(p_uy_vx_reg);
            tn1_reg    <= W'(p_wx_vy1_reg) - W'(p_wy1_vx_reg);
            un1_reg    <= W'(p_wx_uy_reg) - W'(p_wy1_ux_reg);
            den2_reg   <= W'(p_ux_vy2_reg) - W'(p_uy_vx_reg);
            tn2_reg    <= W'(p_wx_vy2_reg) - W'(p_wy2_vx_reg);
            un2_reg    <= W'(p_wx_uy_reg) - W'(p_wy2_ux_reg);

            within_class_reg <= cls;
            score_reg        <= b2_tag_reg.level;
        end
    end

    // parallel lines count as no crossing
    assign cross1 = (den1_reg != ZERO) && in_unit(tn1_reg, den1_reg) &&
                    in_unit(un1_reg, den1_reg);
    assign cross2 = (den2_reg != ZERO) && in_unit(tn2_reg, den2_reg) &&
                    in_unit(un2_reg, den2_reg);

    always_comb
    begin
        priority if (b2_tag_reg.start_in && b2_tag_reg.end_in)
        begin
            cls = CLS_FULL;
        end
        else if (b2_tag_reg.start_in || b2_tag_reg.end_in || cross1 || cross2)
        begin
            cls = CLS_PART;
        end
        else
        begin
            cls = CLS_NONE;
        end
    end

    always_comb
    begin
        b1_valid_next  = en ? q_valid : b1_valid_reg;
        b2_valid_next  = en ? b1_valid_reg : b2_valid_reg;
        out_valid_next = en ? b2_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b1_valid_reg  <= b1_valid_next;
            b2_valid_reg  <= b2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign within_class = within_class_reg;
    assign score        = score_reg;

    a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (within_class_reg == CLS_NONE || within_class_reg == CLS_PART ||
                           within_class_reg == CLS_FULL))
        else $error("result carries an unused class code");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> (b1_valid_reg == $past(b1_valid_reg)) &&
                (b2_valid_reg == $past(b2_valid_reg)))
        else $error("back pipeline moved during a stall");

    a_no_pop_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !pop)
        else $error("queue popped while result held");

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the segment/box overlap classifier top level.
module tb;
    import sbo_pkg::*;

    localparam int CW          = 32;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 81;

    typedef logic signed [CW-1:0]  coord_t;
    typedef logic signed [95:0]    acc_t;
    typedef logic [CLASS_BITS-1:0] cls_t;
    typedef logic [LEVEL_BITS-1:0] level_t;

    localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};

    typedef struct packed {
        coord_t sx, sy, ex, ey;
    } seg_t;

    typedef struct packed {
        coord_t min_x, max_x, min_y, max_y;
        level_t level;
    } box_t;

    typedef struct packed {
        cls_t   cls;
        level_t level;
    } verdict_t;

    typedef struct packed {
        seg_t seg;
        box_t box;
        logic typed;
        cls_t cls;
    } row_t;

    typedef enum {SEG_CORNERS, SEG_POINT, SEG_AXIS, SEG_NEAR, SEG_ANY} seg_shape_t;
    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_wen;
    logic [REG_IDX_BITS-1:0] cfg_addr;
    logic [CW-1:0]           cfg_wdata;
    logic                    in_valid;
    logic                    in_ready;
    coord_t                  box_min_x;
    coord_t                  box_max_x;
    coord_t                  box_min_y;
    coord_t                  box_max_y;
    level_t                  tree_level;
    logic                    out_valid;
    logic                    out_ready;
    cls_t                    within_class;
    level_t                  score;

    verdict_t    pending_verdicts[$];
    row_t        stim_table[$];
    seg_t        seg_now;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          hold_requests  = 0;
    int          n_errors       = 0;
    int          n_boxes        = 0;
    int          n_settings     = 0;
    int          n_full         = 0;
    int          n_part         = 0;
    int          n_none         = 0;

    segment_box_overlap_classifier_top #(
        .COORD_BITS(CW)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wen     (cfg_wen),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .box_min_x   (box_min_x),
        .box_max_x   (box_max_x),
        .box_min_y   (box_min_y),
        .box_max_y   (box_max_y),
        .tree_level  (tree_level),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .within_class(within_class),
        .score       (score)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // num/den within [0,1], den nonzero
    function automatic logic frac_in_unit(input acc_t num, input acc_t den);
        if (den >= 0)
            return (num >= 0) && (num <= den);
        return (num >= den) && (num <= 0);
    endfunction

    function automatic logic lines_cross(input acc_t ax, ay, bx, by, cx, cy, dx, dy);
        acc_t ux, uy, vx, vy, wx, wy, den;
        ux  = bx - ax;
        uy  = by - ay;
        vx  = dx - cx;
        vy  = dy - cy;
        wx  = cx - ax;
        wy  = cy - ay;
        den = ux * vy - uy * vx;
        // parallel, point box or zero-length segment: no crossing
        if (den == 0)
            return 1'b0;
        if (!frac_in_unit(wx * vy - wy * vx, den))
            return 1'b0;
        return frac_in_unit(wx * uy - wy * ux, den);
    endfunction

    function automatic cls_t classify_box(input seg_t s, input box_t b);
        coord_t sx, sy, ex, ey, x0, x1, y0, y1;
        logic   hit_s, hit_e;
        sx = s.sx;
        sy = s.sy;
        ex = s.ex;
        ey = s.ey;
        x0 = b.min_x;
        x1 = b.max_x;
        y0 = b.min_y;
        y1 = b.max_y;
        hit_s = (x0 <= sx) && (sx <= x1) && (y0 <= sy) && (sy <= y1);
        hit_e = (x0 <= ex) && (ex <= x1) && (y0 <= ey) && (ey <= y1);
        if (hit_s && hit_e)
            return CLS_FULL;
        if (hit_s || hit_e)
            return CLS_PART;
        if (lines_cross(sx, sy, ex, ey, x0, y0, x1, y1) ||
            lines_cross(sx, sy, ex, ey, x0, y1, x1, y0))
            return CLS_PART;
        return CLS_NONE;
    endfunction

    function automatic seg_t mk_seg(input coord_t sx, sy, ex, ey);
        seg_t s;
        s.sx = sx;
        s.sy = sy;
        s.ex = ex;
        s.ey = ey;
        return s;
    endfunction

    function automatic box_t mk_box(input coord_t x0, x1, y0, y1, input int unsigned lvl);
        box_t b;
        b.min_x = x0;
        b.max_x = x1;
        b.min_y = y0;
        b.max_y = y1;
        b.level = level_t'(lvl);
        return b;
    endfunction

    function automatic coord_t jitter(input coord_t c, input int unsigned span);
        coord_t off;
        off = coord_t'($urandom_range(span));
        if ($urandom_range(1))
            off = -off;
        return c + off;
    endfunction

    function automatic coord_t grow(input int unsigned span);
        if ($urandom_range(3) == 0)
            return '0;
        return coord_t'($urandom_range(span));
    endfunction

    function automatic seg_shape_t phase_shape(input int ph);
        case (ph)
            0, 6:    return SEG_CORNERS;
            2:       return SEG_AXIS;
            3:       return SEG_ANY;
            4:       return SEG_POINT;
            default: return SEG_NEAR;
        endcase
    endfunction

    function automatic int unsigned shape_span(input seg_shape_t shape);
        case (shape)
            SEG_CORNERS: return 32'h7fff_ffff;
            SEG_AXIS:    return 1 << 16;
            SEG_ANY:     return 1 << 30;
            default:     return 1 << 20;
        endcase
    endfunction

    function automatic seg_t make_segment(input seg_shape_t shape);
        seg_t   s;
        coord_t cx, cy;
        case (shape)
            SEG_CORNERS:
            begin
                s.sx = $urandom_range(1) ? C_MAX : C_MIN;
                s.sy = $urandom_range(1) ? C_MAX : C_MIN;
                s.ex = $urandom_range(1) ? C_MAX : C_MIN;
                s.ey = $urandom_range(1) ? C_MAX : C_MIN;
            end
            SEG_POINT:
            begin
                s.sx = jitter('0, 1 << 20);
                s.sy = jitter('0, 1 << 20);
                s.ex = s.sx;
                s.ey = s.sy;
            end
            SEG_AXIS:
            begin
                cx = jitter('0, 1 << 16);
                cy = jitter('0, 1 << 16);
                if ($urandom_range(1))
                begin
                    s.sx = cx;
                    s.ex = cx;
                    s.sy = jitter(cy, 1 << 16);
                    s.ey = jitter(cy, 1 << 16);
                end
                else
                begin
                    s.sy = cy;
                    s.ey = cy;
                    s.sx = jitter(cx, 1 << 16);
                    s.ex = jitter(cx, 1 << 16);
                end
            end
            SEG_NEAR:
            begin
                s.sx = jitter('0, 1 << 20);
                s.sy = jitter('0, 1 << 20);
                s.ex = jitter('0, 1 << 20);
                s.ey = jitter('0, 1 << 20);
            end
            default:
            begin
                s.sx = coord_t'($urandom);
                s.sy = coord_t'($urandom);
                s.ex = coord_t'($urandom);
                s.ey = coord_t'($urandom);
            end
        endcase
        return s;
    endfunction

    // Boxes are mostly placed around the segment so that all three classes turn up.
    function automatic box_t make_box(input seg_t s, input int unsigned span);
        box_t        b;
        coord_t      sx, sy, ex, ey, px, py, t;
        int unsigned pick;
        sx    = s.sx;
        sy    = s.sy;
        ex    = s.ex;
        ey    = s.ey;
        pick  = $urandom_range(99);
        b.level = level_t'($urandom_range(63));
        if (pick < 10)
        begin
            b.min_x = coord_t'($urandom);
            b.max_x = coord_t'($urandom);
            b.min_y = coord_t'($urandom);
            b.max_y = coord_t'($urandom);
            return b;
        end
        if (pick < 30)
        begin
            // wrap both endpoints
            b.min_x = ((sx < ex) ? sx : ex) - grow(span >> 3);
            b.max_x = ((sx < ex) ? ex : sx) + grow(span >> 3);
            b.min_y = ((sy < ey) ? sy : ey) - grow(span >> 3);
            b.max_y = ((sy < ey) ? ey : sy) + grow(span >> 3);
        end
        else
        begin
            case ($urandom_range(2))
                0:
                begin
                    px = sx;
                    py = sy;
                end
                1:
                begin
                    px = ex;
                    py = ey;
                end
                default:
                begin
                    px = (sx >>> 1) + (ex >>> 1);
                    py = (sy >>> 1) + (ey >>> 1);
                end
            endcase
            px = jitter(px, span);
            py = jitter(py, span);
            b.min_x = px - grow(span);
            b.max_x = px + grow(span);
            b.min_y = py - grow(span);
            b.max_y = py + grow(span);
            if ($urandom_range(19) == 0)
                b.max_x = b.min_x;
            if ($urandom_range(19) == 0)
                b.max_y = b.min_y;
        end
        if ($urandom_range(99) < 15)
        begin
            t       = b.min_x;
            b.min_x = b.max_x;
            b.max_x = t;
        end
        if ($urandom_range(99) < 15)
        begin
            t       = b.min_y;
            b.min_y = b.max_y;
            b.max_y = t;
        end
        return b;
    endfunction

    task automatic put_row(input seg_t s, input box_t b, input logic typed, input cls_t c);
        row_t r;
        r.seg   = s;
        r.box   = b;
        r.typed = typed;
        r.cls   = c;
        stim_table.push_back(r);
    endtask

    task automatic offer_box(input box_t b, input cls_t c);
        verdict_t v;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        box_min_x  <= b.min_x;
        box_max_x  <= b.max_x;
        box_min_y  <= b.min_y;
        box_max_y  <= b.max_y;
        tree_level <= b.level;
        do
            @(posedge clk);
        while (!in_ready);
        v.cls   = c;
        v.level = b.level;
        pending_verdicts.push_back(v);
        n_boxes++;
        if (c == CLS_FULL)
            n_full++;
        else if (c == CLS_PART)
            n_part++;
        else
            n_none++;
    endtask

    // Drop valid and hold until every pending result has come back.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_verdicts.size() != 0);
    endtask

    task automatic program_segment(input seg_t s);
        cfg_wen   <= 1'b1;
        cfg_addr  <= REG_SEG_START_X;
        cfg_wdata <= s.sx;
        @(posedge clk);
        cfg_addr  <= REG_SEG_START_Y;
        cfg_wdata <= s.sy;
        @(posedge clk);
        cfg_addr  <= REG_SEG_END_X;
        cfg_wdata <= s.ex;
        @(posedge clk);
        cfg_addr  <= REG_SEG_END_Y;
        cfg_wdata <= s.ey;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        seg_now = s;
        n_settings++;
    endtask

    initial
    begin : sink
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : scoreboard
        verdict_t v;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("result with no request pending: within_class %0d score %0d",
                       within_class, score);
                n_errors++;
            end
            else
            begin
                v = pending_verdicts.pop_front();
                if (within_class !== v.cls)
                begin
                    $error("within_class: expected %0d, actual %0d", v.cls, within_class);
                    n_errors++;
                end
                if (score !== v.level)
                begin
                    $error("score: expected %0d, actual %0d", v.level, score);
                    n_errors++;
                end
            end
        end
    end

    initial
    begin : stimulus
        row_t        rw;
        box_t        b;
        seg_t        s0, s1, s2, s3;
        seg_shape_t  shape;
        int unsigned span;

        rst_n      <= 1'b0;
        cfg_wen    <= 1'b0;
        cfg_addr   <= REG_SEG_START_X;
        cfg_wdata  <= '0;
        in_valid   <= 1'b0;
        box_min_x  <= '0;
        box_max_x  <= '0;
        box_min_y  <= '0;
        box_max_y  <= '0;
        tree_level <= '0;
        seg_now = '0;

        // point segment at the origin, as left by reset
        s0 = mk_seg(0, 0, 0, 0);
        put_row(s0, mk_box(-1, 1, -1, 1, 0), 1'b1, CLS_FULL);
        put_row(s0, mk_box(1, 2, 1, 2, 63), 1'b1, CLS_NONE);
        put_row(s0, mk_box(0, 0, 0, 0, 21), 1'b1, CLS_FULL);
        put_row(s0, mk_box(C_MIN, C_MAX, C_MIN, C_MAX, 42), 1'b1, CLS_FULL);
        put_row(s0, mk_box(1, -1, -1, 1, 7), 1'b1, CLS_NONE);
        // full-range diagonal segment
        s1 = mk_seg(C_MIN, C_MIN, C_MAX, C_MAX);
        put_row(s1, mk_box(C_MIN, C_MAX, C_MIN, C_MAX, 63), 1'b1, CLS_FULL);
        put_row(s1, mk_box(C_MIN, C_MIN, C_MIN, C_MIN, 0), 1'b1, CLS_PART);
        put_row(s1, mk_box(C_MAX, C_MAX, C_MAX, C_MAX, 1), 1'b1, CLS_PART);
        put_row(s1, mk_box(0, 10, 0, 10, 2), 1'b0, CLS_NONE);
        put_row(s1, mk_box(C_MAX, C_MIN, C_MAX, C_MIN, 3), 1'b0, CLS_NONE);
        // horizontal segment
        s2 = mk_seg(-100, 5, 100, 5);
        put_row(s2, mk_box(0, 10, 0, 10, 4), 1'b0, CLS_NONE);
        put_row(s2, mk_box(0, 10, 6, 10, 5), 1'b0, CLS_NONE);
        // diagonal starts on the segment
        put_row(s2, mk_box(50, 60, 5, 15, 6), 1'b0, CLS_NONE);
        // inverted box holds nothing, but its diagonals still cross
        put_row(s2, mk_box(10, 0, 0, 10, 8), 1'b0, CLS_NONE);
        // collinear flat box beyond the segment
        put_row(s2, mk_box(-200, -150, 5, 5, 9), 1'b0, CLS_NONE);
        put_row(s2, mk_box(100, 200, -5, 5, 10), 1'b1, CLS_PART);
        put_row(s2, mk_box(-100, 100, 5, 5, 11), 1'b1, CLS_FULL);
        // vertical full-height segment
        s3 = mk_seg(7, C_MIN, 7, C_MAX);
        put_row(s3, mk_box(0, 10, -10, 10, 12), 1'b0, CLS_NONE);
        put_row(s3, mk_box(8, 20, C_MIN, C_MAX, 13), 1'b0, CLS_NONE);
        put_row(s3, mk_box(C_MIN, C_MAX, C_MIN, C_MAX, 14), 1'b1, CLS_FULL);
        put_row(s3, mk_box(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555, 42),
                1'b0, CLS_NONE);
        put_row(s3, mk_box(-1, -1, -1, -1, 21), 1'b0, CLS_NONE);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
        begin
            rw = stim_table[i];
            if (rw.seg != seg_now)
            begin
                settle();
                program_segment(rw.seg);
            end
            offer_box(rw.box, rw.typed ? rw.cls : classify_box(seg_now, rw.box));
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            shape = phase_shape(ph);
            span  = shape_span(shape);
            program_segment(make_segment(shape));
            case (idle_mode_t'(ph % 4))
                IDLE_NONE:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                IDLE_SEND:
                begin
                    send_idle_pct  = 61;
                    recv_stall_pct = 0;
                end
                IDLE_RECV:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 61;
                end
                default:
                begin
                    send_idle_pct  = 31;
                    recv_stall_pct = 31;
                end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // long receiver hold-off while requests keep coming
                if (ph == 2 && k == 20)
                    hold_requests++;
                if (ph == 5 && k == 40)
                    settle();
                b = make_box(seg_now, span);
                offer_box(b, classify_box(seg_now, b));
            end
        end

        settle();
        repeat (8) @(posedge clk);
        $display("covered %0d boxes under %0d segment settings, with idle and stall phases",
                 n_boxes, n_settings);
        $display("classes seen: %0d fully, %0d partly, %0d not within",
                 n_full, n_part, n_none);
        if (n_errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("tb failed");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/sbo_pkg.sv
hw/rtl/sbo_queue.sv
hw/rtl/sbo_front.sv
hw/rtl/sbo_back.sv
hw/rtl/segment_box_overlap_classifier_top.sv
verif/tb.sv
